### design/rmb_pkg.sv
// rmb_pkg: shared types and constants for the ring load table
// no dependencies
package rmb_pkg;

  localparam int Capacity  = 1024;
  localparam int IdxBits   = 10;
  localparam int CntBits   = 11;
  localparam int LoadBits  = 32;
  localparam int AlphaBits = 16;
  localparam int TotBits   = LoadBits + IdxBits;
  localparam int ProdBits  = LoadBits + AlphaBits;

  localparam logic [LoadBits-1:0]  LoadMax     = '1;
  localparam logic [CntBits-1:0]   CountReset  = 11'd1024;
  localparam logic [AlphaBits-1:0] AlphaReset  = 16'd22380;
  localparam logic [CntBits-1:0]   CountMin    = 11'd2;
  localparam logic [CntBits-1:0]   CountMax    = 11'd1024;

  localparam logic [7:0] RegNodeCount = 8'd0;
  localparam logic [7:0] RegAlpha     = 8'd1;

  localparam logic KindInsert = 1'b0;
  localparam logic KindQuery  = 1'b1;

  typedef enum logic [4:0] {
    ST_CLEAR, ST_IDLE, ST_QRUN, ST_IRD, ST_IINC, ST_ISCAN, ST_IMUL, ST_ICMP,
    ST_INB, ST_INB2, ST_INB3, ST_IDN, ST_IZERO, ST_IX, ST_IX2, ST_IUP,
    ST_ISPL, ST_ISPL2, ST_OUT
  } state_t;

endpackage

### design/ring_min_balance_load_table_core.sv
// ring_min_balance_load_table_core: ring load table with min-node merge and split
// depends on rmb_pkg and rmb_load_ram
//
// usage: a word is taken when start is high and busy is low. kind 0 adds one
// item to node_index when it lies inside the ring and may merge the lightest
// node into a neighbour and split the loaded node; kind 1 counts the nodes
// whose key run meets [range_start, range_end]. each word gives one result on
// node_hits, rebalanced and load_saturated, strobed by done for exactly one
// cycle; the receiver cannot stall it. busy stays high until that cycle ends.
// registers are written through cfg_valid/cfg_ready (always ready) with
// cfg_index 0 node_count and 1 alpha_q12; the user must write them only
// while the block is idle, which the block itself does not enforce.
// the single memory port pair, one load read and one written a cycle, lets
// the minimum scan, both shift passes and the prefix walk run one node a cycle.
// after reset a clearing pass writes zero to all 1024 entries with busy high;
// configuration writes are taken.
module ring_min_balance_load_table_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [9:0]  node_index,
  input  logic [31:0] range_start,
  input  logic [31:0] range_end,
  output logic        done,
  output logic [10:0] node_hits,
  output logic        rebalanced,
  output logic        load_saturated,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IB = rmb_pkg::IdxBits;
  localparam int CB = rmb_pkg::CntBits;
  localparam int LB = rmb_pkg::LoadBits;
  localparam int TB = rmb_pkg::TotBits;
  localparam int PB = rmb_pkg::ProdBits;

  rmb_pkg::state_t state, state_next;

  logic [CB-1:0] node_count;
  logic [15:0]   alpha;
  logic [CB-1:0] n, n_next;
  logic [IB-1:0] ip, ip_next;
  logic          iss, iss_next;
  logic          rv;
  logic [IB-1:0] ra;
  logic [IB-1:0] u, u_next;
  logic [31:0]   s_q, s_next, e_q, e_next;
  logic [LB-1:0] lu, lu_next, minv, minv_next, ll, ll_next, x, x_next;
  logic          sat_q, sat_next;
  logic [IB-1:0] v, v_next;
  logic [PB-1:0] prod, prod_next;
  logic [TB-1:0] tot, tot_next;
  logic [CB-1:0] hits, hits_next;
  logic          reb, reb_next;

  logic          we, re;
  logic [IB-1:0] waddr, raddr;
  logic [LB-1:0] wdata, rdata;

  logic [IB-1:0] nm1, lft, rgt;
  logic [TB-1:0] tsum;
  logic [LB:0]   zsum;
  logic [LB-1:0] lr_min;
  logic [CB-1:0] n_clamp;

  rmb_load_ram u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state != rmb_pkg::ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      node_count <= rmb_pkg::CountReset;
      alpha      <= rmb_pkg::AlphaReset;
    end else if (cfg_valid) begin
      if (cfg_index == rmb_pkg::RegNodeCount) begin
        node_count <= cfg_data[CB-1:0];
      end else if (cfg_index == rmb_pkg::RegAlpha) begin
        alpha <= cfg_data;
      end
    end
  end

  always_comb begin
    if (node_count < rmb_pkg::CountMin) begin
      n_clamp = rmb_pkg::CountMin;
    end else if (node_count > rmb_pkg::CountMax) begin
      n_clamp = rmb_pkg::CountMax;
    end else begin
      n_clamp = node_count;
    end
  end

  assign nm1    = IB'(n - CB'(1));
  assign lft    = (v == '0) ? nm1 : IB'(v - IB'(1));
  assign rgt    = (v == nm1) ? '0 : IB'(v + IB'(1));
  assign tsum   = tot + TB'(rdata);
  assign lr_min = (ll < rdata) ? ll : rdata;
  assign zsum   = {1'b0, lr_min} + {1'b0, minv};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rmb_pkg::ST_CLEAR;
      ip    <= '0;
      iss   <= 1'b0;
      rv    <= 1'b0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      ip    <= ip_next;
      iss   <= iss_next;
      rv    <= re;
      done  <= (state_next == rmb_pkg::ST_OUT);
    end
  end

  always_ff @(posedge clk) begin
    ra    <= raddr;
    n     <= n_next;
    u     <= u_next;
    s_q   <= s_next;
    e_q   <= e_next;
    lu    <= lu_next;
    sat_q <= sat_next;
    minv  <= minv_next;
    v     <= v_next;
    prod  <= prod_next;
    ll    <= ll_next;
    x     <= x_next;
    tot   <= tot_next;
    hits  <= hits_next;
    reb   <= reb_next;
  end

  // result ports hold the last word
  always_ff @(posedge clk) begin
    if (state_next == rmb_pkg::ST_OUT && state != rmb_pkg::ST_OUT) begin
      node_hits      <= hits_next;
      rebalanced     <= reb_next;
      load_saturated <= sat_next;
    end
  end

  always_comb begin
    state_next = state;
    ip_next    = ip;
    iss_next   = iss;
    n_next     = n;
    u_next     = u;
    s_next     = s_q;
    e_next     = e_q;
    lu_next    = lu;
    sat_next   = sat_q;
    minv_next  = minv;
    v_next     = v;
    prod_next  = prod;
    ll_next    = ll;
    x_next     = x;
    tot_next   = tot;
    hits_next  = hits;
    reb_next   = reb;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    re         = 1'b0;
    raddr      = '0;

    unique case (state)
      rmb_pkg::ST_CLEAR: begin
        we      = 1'b1;
        waddr   = ip;
        ip_next = IB'(ip + IB'(1));
        if (ip == IB'(rmb_pkg::Capacity - 1)) begin
          state_next = rmb_pkg::ST_IDLE;
        end
      end
      rmb_pkg::ST_IDLE: begin
        if (start) begin
          n_next    = n_clamp;
          u_next    = node_index;
          s_next    = range_start;
          e_next    = range_end;
          hits_next = '0;
          reb_next  = 1'b0;
          sat_next  = 1'b0;
          tot_next  = '0;
          ip_next   = '0;
          iss_next  = 1'b1;
          if (kind == rmb_pkg::KindQuery) begin
            state_next = rmb_pkg::ST_QRUN;
          end else if (CB'(node_index) >= n_clamp) begin
            state_next = rmb_pkg::ST_OUT;
          end else begin
            state_next = rmb_pkg::ST_IRD;
          end
        end
      end
      rmb_pkg::ST_QRUN: begin
        if (iss) begin
          re    = 1'b1;
          raddr = ip;
          if (ip == nm1) iss_next = 1'b0;
          else ip_next = IB'(ip + IB'(1));
        end
        if (rv) begin
          tot_next = tsum;
          if (tsum > TB'(e_q)) begin
            // node straddles the range end: count it if it starts at or before the range end
            if (tot + TB'(1) <= TB'(e_q)) hits_next = CB'(hits + CB'(1));
            iss_next   = 1'b0;
            state_next = rmb_pkg::ST_OUT;
          end else begin
            if (TB'(s_q) <= tsum) hits_next = CB'(hits + CB'(1));
            if (ra == nm1) state_next = rmb_pkg::ST_OUT;
          end
        end
      end
      rmb_pkg::ST_IRD: begin
        re         = 1'b1;
        raddr      = u;
        state_next = rmb_pkg::ST_IINC;
      end
      rmb_pkg::ST_IINC: begin
        lu_next    = (rdata == rmb_pkg::LoadMax) ? rdata : LB'(rdata + LB'(1));
        sat_next   = (lu_next == rmb_pkg::LoadMax);
        we         = 1'b1;
        waddr      = u;
        wdata      = lu_next;
        ip_next    = '0;
        iss_next   = 1'b1;
        state_next = rmb_pkg::ST_ISCAN;
      end
      rmb_pkg::ST_ISCAN: begin
        if (iss) begin
          re    = 1'b1;
          raddr = ip;
          if (ip == nm1) iss_next = 1'b0;
          else ip_next = IB'(ip + IB'(1));
        end
        if (rv) begin
          if (ra == '0 || rdata < minv) begin
            minv_next = rdata;
            v_next    = ra;
          end
          if (ra == nm1) state_next = rmb_pkg::ST_IMUL;
        end
      end
      rmb_pkg::ST_IMUL: begin
        prod_next  = PB'(alpha) * PB'(minv);
        state_next = rmb_pkg::ST_ICMP;
      end
      rmb_pkg::ST_ICMP: begin
        if ({4'b0, lu, 12'b0} > prod) begin
          reb_next   = 1'b1;
          state_next = rmb_pkg::ST_INB;
        end else begin
          state_next = rmb_pkg::ST_OUT;
        end
      end
      rmb_pkg::ST_INB: begin
        re         = 1'b1;
        raddr      = lft;
        state_next = rmb_pkg::ST_INB2;
      end
      rmb_pkg::ST_INB2: begin
        re         = 1'b1;
        raddr      = rgt;
        ll_next    = rdata;
        state_next = rmb_pkg::ST_INB3;
      end
      rmb_pkg::ST_INB3: begin
        // merge into the lighter neighbour, right one on ties
        we    = 1'b1;
        waddr = (ll < rdata) ? lft : rgt;
        wdata = zsum[LB] ? rmb_pkg::LoadMax : zsum[LB-1:0];
        if (v == nm1) begin
          state_next = rmb_pkg::ST_IZERO;
        end else begin
          ip_next    = IB'(v + IB'(1));
          iss_next   = 1'b1;
          state_next = rmb_pkg::ST_IDN;
        end
      end
      rmb_pkg::ST_IDN: begin
        if (iss) begin
          re    = 1'b1;
          raddr = ip;
          if (ip == nm1) iss_next = 1'b0;
          else ip_next = IB'(ip + IB'(1));
        end
        if (rv) begin
          we    = 1'b1;
          waddr = IB'(ra - IB'(1));
          wdata = rdata;
          if (ra == nm1) state_next = rmb_pkg::ST_IZERO;
        end
      end
      rmb_pkg::ST_IZERO: begin
        we         = 1'b1;
        waddr      = nm1;
        wdata      = '0;
        if (v < u) u_next = IB'(u - IB'(1));
        state_next = rmb_pkg::ST_IX;
      end
      rmb_pkg::ST_IX: begin
        re         = 1'b1;
        raddr      = u;
        state_next = rmb_pkg::ST_IX2;
      end
      rmb_pkg::ST_IX2: begin
        x_next = rdata;
        if (u == nm1) begin
          state_next = rmb_pkg::ST_ISPL;
        end else begin
          ip_next    = IB'(nm1 - IB'(1));
          iss_next   = 1'b1;
          state_next = rmb_pkg::ST_IUP;
        end
      end
      rmb_pkg::ST_IUP: begin
        if (iss) begin
          re    = 1'b1;
          raddr = ip;
          if (ip == u) iss_next = 1'b0;
          else ip_next = IB'(ip - IB'(1));
        end
        if (rv) begin
          we    = 1'b1;
          waddr = IB'(ra + IB'(1));
          wdata = rdata;
          if (ra == u) state_next = rmb_pkg::ST_ISPL;
        end
      end
      rmb_pkg::ST_ISPL: begin
        we         = 1'b1;
        waddr      = u;
        wdata      = x >> 1;
        state_next = rmb_pkg::ST_ISPL2;
      end
      rmb_pkg::ST_ISPL2: begin
        if (u != nm1) begin
          we    = 1'b1;
          waddr = IB'(u + IB'(1));
          wdata = LB'(x - (x >> 1));
        end
        state_next = rmb_pkg::ST_OUT;
      end
      rmb_pkg::ST_OUT: begin
        state_next = rmb_pkg::ST_IDLE;
      end
      default: begin
        state_next = rmb_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

### design/rmb_load_ram.sv
// rmb_load_ram: node load store, one write and one registered read port
// depends on rmb_pkg
module rmb_load_ram (
  input  logic                              clk,
  input  logic                              we,
  input  logic [rmb_pkg::IdxBits-1:0]       waddr,
  input  logic [rmb_pkg::LoadBits-1:0]      wdata,
  input  logic                              re,
  input  logic [rmb_pkg::IdxBits-1:0]       raddr,
  output logic [rmb_pkg::LoadBits-1:0]      rdata
);

  logic [rmb_pkg::LoadBits-1:0] mem [rmb_pkg::Capacity];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### tb/sv/tb_ring_min_balance_load_table_core.sv
// tb_ring_min_balance_load_table_core: self-checking bench for the ring load table
// depends on rmb_pkg and ring_min_balance_load_table_core
// each accepted word is predicted in the bench and checked against the strobed result
module tb_ring_min_balance_load_table_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IB = rmb_pkg::IdxBits;
  localparam int CB = rmb_pkg::CntBits;
  localparam int LB = rmb_pkg::LoadBits;
  localparam int AB = rmb_pkg::AlphaBits;

  typedef struct {
    logic [CB-1:0] hits;
    logic          reb;
    logic          sat;
  } ring_result_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic                 kind = rmb_pkg::KindInsert;
  logic [IB-1:0]        node_index = '0;
  logic [31:0]          range_start = '0;
  logic [31:0]          range_end = '0;
  logic                 done;
  logic [CB-1:0]        node_hits;
  logic                 rebalanced;
  logic                 load_saturated;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [7:0]           cfg_index = '0;
  logic [15:0]          cfg_data = '0;

  // bench copy of the table and registers
  logic [LB-1:0]        ring_load [rmb_pkg::Capacity];
  logic [CB-1:0]        count_reg;
  logic [AB-1:0]        alpha_reg;
  ring_result_t         expected_results [$];
  int                   fail_count = 0;
  longint               cycle_count = 0;

  ring_min_balance_load_table_core u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .kind(kind),
    .node_index(node_index), .range_start(range_start), .range_end(range_end),
    .done(done), .node_hits(node_hits), .rebalanced(rebalanced),
    .load_saturated(load_saturated), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 64'd3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic int unsigned ring_size();
    if (count_reg < rmb_pkg::CountMin) return rmb_pkg::CountMin;
    if (count_reg > rmb_pkg::CountMax) return rmb_pkg::CountMax;
    return count_reg;
  endfunction

  function automatic logic [LB-1:0] load_sum(logic [LB-1:0] a, logic [LB-1:0] b);
    logic [LB:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[LB] ? rmb_pkg::LoadMax : s[LB-1:0];
  endfunction

  function automatic longint unsigned ring_total();
    longint unsigned tot;
    tot = 0;
    for (int i = 0; i < ring_size(); i++) tot += ring_load[i];
    return tot;
  endfunction

  // merge the lightest node into a neighbour and split the loaded one
  function automatic logic merge_and_split(int unsigned u, int unsigned n);
    int unsigned v, l, r, z;
    logic [LB-1:0] x;
    v = 0;
    for (int i = 1; i < n; i++) if (ring_load[i] < ring_load[v]) v = i;
    if (64'(ring_load[u]) * 64'd4096 <= 64'(alpha_reg) * 64'(ring_load[v])) return 1'b0;
    l = (v == 0) ? n - 1 : v - 1;
    r = (v + 1 == n) ? 0 : v + 1;
    z = (ring_load[l] < ring_load[r]) ? l : r;
    ring_load[z] = load_sum(ring_load[z], ring_load[v]);
    for (int i = v; i + 1 < n; i++) ring_load[i] = ring_load[i+1];
    ring_load[n-1] = '0;
    if (v < u) u--;
    x = ring_load[u];
    for (int i = n - 1; i > u; i--) ring_load[i] = ring_load[i-1];
    ring_load[u] = x >> 1;
    if (u + 1 < n) ring_load[u+1] = x - (x >> 1);
    return 1'b1;
  endfunction

  function automatic ring_result_t predict_word(logic k, logic [IB-1:0] idx,
                                                logic [31:0] s, logic [31:0] e);
    ring_result_t res;
    int unsigned n;
    longint unsigned tot, hits;
    n = ring_size();
    res = '{hits: '0, reb: 1'b0, sat: 1'b0};
    if (k == rmb_pkg::KindQuery) begin
      tot = 0;
      hits = 0;
      for (int i = 0; i < n; i++) begin
        tot += ring_load[i];
        if (tot > e) begin
          if (tot - ring_load[i] + 1 <= e) hits++;
          break;
        end
        if (s <= tot) hits++;
      end
      res.hits = (hits > 2047) ? 11'd2047 : hits[CB-1:0];
    end else if (idx < n) begin
      ring_load[idx] = load_sum(ring_load[idx], LB'(1));
      res.sat = (ring_load[idx] == rmb_pkg::LoadMax);
      res.reb = merge_and_split(idx, n);
    end
    return res;
  endfunction

  // result checker: the block cannot be stalled, so every strobe is a word
  always @(posedge clk) begin
    ring_result_t exp_r;
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $error("result with nothing expected");
        fail_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (node_hits !== exp_r.hits) begin
          $error("node_hits expected %0d got %0d", exp_r.hits, node_hits);
          fail_count++;
        end
        if (rebalanced !== exp_r.reb) begin
          $error("rebalanced expected %0d got %0d", exp_r.reb, rebalanced);
          fail_count++;
        end
        if (load_saturated !== exp_r.sat) begin
          $error("load_saturated expected %0d got %0d", exp_r.sat, load_saturated);
          fail_count++;
        end
      end
    end
  end

  task automatic send_word(logic k, logic [IB-1:0] idx, logic [31:0] s,
                           logic [31:0] e, int unsigned gap);
    ring_result_t res;
    @(negedge clk);
    start <= 1'b1;
    kind <= k;
    node_index <= idx;
    range_start <= s;
    range_end <= e;
    do @(posedge clk); while (busy);
    res = predict_word(k, idx, s, e);
    expected_results = {expected_results, res};
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  function automatic int unsigned random_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 92) return $urandom_range(1, 4);
    return $urandom_range(20, 120);
  endfunction

  task automatic wait_idle();
    @(negedge clk);
    start <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [7:0] idx, logic [15:0] data);
    wait_idle();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    if (idx == rmb_pkg::RegNodeCount) count_reg = data[CB-1:0];
    else if (idx == rmb_pkg::RegAlpha) alpha_reg = data;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_reset_ring();
    send_word(rmb_pkg::KindInsert, 10'd0, '0, '0, 0);
    send_word(rmb_pkg::KindInsert, 10'd1023, '0, '0, 2);
    send_word(rmb_pkg::KindQuery, '0, 32'd0, 32'd0, 0);
    send_word(rmb_pkg::KindQuery, '0, 32'd0, 32'hFFFF_FFFF, 1);
  endtask

  task automatic test_small_ring();
    write_reg(rmb_pkg::RegNodeCount, 16'd0);  // acts as two nodes
    write_reg(rmb_pkg::RegAlpha, 16'd4096);
    send_word(rmb_pkg::KindInsert, 10'd0, '0, '0, 0);
    send_word(rmb_pkg::KindInsert, 10'd1, '0, '0, 0);
    send_word(rmb_pkg::KindInsert, 10'd1, '0, '0, 3);
    // out of ring
    send_word(rmb_pkg::KindInsert, 10'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(rmb_pkg::KindInsert, 10'd1023, '0, '0, 0);
    send_word(rmb_pkg::KindQuery, '0, 32'd0, 32'd0, 0);
    send_word(rmb_pkg::KindQuery, '0, 32'd0, 32'hFFFF_FFFF, 0);
    send_word(rmb_pkg::KindQuery, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0);
    send_word(rmb_pkg::KindQuery, '0, 32'd5, 32'd2, 0);
    write_reg(rmb_pkg::RegNodeCount, 16'd1);
    send_word(rmb_pkg::KindInsert, 10'd0, '0, '0, 0);
  endtask

  task automatic test_alpha_extremes();
    write_reg(rmb_pkg::RegNodeCount, 16'd3);
    write_reg(rmb_pkg::RegAlpha, 16'd0);  // alpha below one: min node may be the loaded one
    send_word(rmb_pkg::KindInsert, 10'd2, '0, '0, 0);
    send_word(rmb_pkg::KindInsert, 10'd2, '0, '0, 0);
    send_word(rmb_pkg::KindInsert, 10'd0, '0, '0, 0);
    send_word(rmb_pkg::KindQuery, '0, 32'd1, 32'd2, 0);
    write_reg(rmb_pkg::RegAlpha, 16'd65535);
    write_reg(rmb_pkg::RegNodeCount, 16'd2047);  // clamps to full capacity
    send_word(rmb_pkg::KindInsert, 10'd512, '0, '0, 0);
    send_word(rmb_pkg::KindQuery, '0, 32'd0, 32'd1, 0);
  endtask

  task automatic test_random_phases();
    int unsigned tot, s, e, p;
    logic [IB-1:0] idx;
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(rmb_pkg::RegNodeCount,
                (ph == 7) ? 16'd200 : 16'($urandom_range(2, 48)));
      p = $urandom_range(0, 9);
      write_reg(rmb_pkg::RegAlpha, (p == 0) ? 16'($urandom_range(0, 4095)) :
                          (p == 1) ? 16'd4096 : (p == 2) ? 16'd65535 :
                          16'($urandom_range(4096, 65535)));
      for (int i = 0; i < 35; i++) begin
        if ($urandom_range(0, 9) < 6) begin
          idx = ($urandom_range(0, 9) == 0) ? 10'($urandom) :
                10'($urandom_range(0, ring_size() - 1));
          send_word(rmb_pkg::KindInsert, idx, $urandom, $urandom, random_gap());
        end else begin
          tot = 32'(ring_total());
          if ($urandom_range(0, 7) == 0) begin
            s = $urandom;
            e = $urandom;
          end else begin
            s = $urandom_range(0, tot + 2);
            e = s + $urandom_range(0, tot + 1);
            if ($urandom_range(0, 9) == 0) e = $urandom_range(0, s);
          end
          send_word(rmb_pkg::KindQuery, 10'($urandom), s, e, random_gap());
        end
      end
    end
  endtask

  initial begin
    foreach (ring_load[i]) ring_load[i] = '0;
    count_reg = rmb_pkg::CountReset;
    alpha_reg = rmb_pkg::AlphaReset;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_ring();
    test_small_ring();
    test_alpha_extremes();
    test_random_phases();
    wait_idle();
    repeat (100) @(posedge clk);
    if (expected_results.size() != 0) begin
      $error("%0d results never arrived", expected_results.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### ring_min_balance_load_table_core.f
design/rmb_pkg.sv
design/rmb_load_ram.sv
design/ring_min_balance_load_table_core.sv
tb/sv/tb_ring_min_balance_load_table_core.sv
